@@ rtl/szt_pkg.sv @@
// Package with the constants, codes and types of the sphere zone tracker.
package szt_pkg;

   localparam int MAX_ZONES  = 16;
   localparam int COORD_BITS = 24;
   localparam int IDX_W      = $clog2(MAX_ZONES);
   localparam int CNT_W      = $clog2(MAX_ZONES + 1);
   localparam int RAD_W      = COORD_BITS - 1;
   localparam int MAG_W      = COORD_BITS + 1;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int ACC_W      = SQ_W + 2;
   localparam int SND_W      = 43;

   localparam logic [2:0] REQ_ADD    = 3'd0;
   localparam logic [2:0] REQ_REMOVE = 3'd1;
   localparam logic [2:0] REQ_CLEAR  = 3'd2;
   localparam logic [2:0] REQ_UPDATE = 3'd3;
   localparam logic [2:0] REQ_LOOKUP = 3'd4;

   localparam logic [2:0] KIND_DONE   = 3'd0;
   localparam logic [2:0] KIND_FULL   = 3'd1;
   localparam logic [2:0] KIND_EXIT   = 3'd2;
   localparam logic [2:0] KIND_ENTER  = 3'd3;
   localparam logic [2:0] KIND_LOOKUP = 3'd4;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
      logic [RAD_W-1:0]             radius;
      logic                         enable;
      logic [SND_W-1:0]             snd;
      logic [15:0]                  tag;
   } zone_row_type;

   typedef struct packed {
      logic [2:0]                   req_type;
      logic [15:0]                  zone_tag;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic [RAD_W-1:0]             radius;
      logic                         enable;
      logic [SND_W-1:0]             snd;
   } req_item_type;

   typedef struct packed {
      logic [2:0]       result_kind;
      logic [15:0]      event_tag;
      logic             found;
      logic [SND_W-1:0] snd;
      logic             inside_now;
      logic [2:0]       effective_preset;
      logic             last_of_run;
   } rsp_item_type;

endpackage

@@ rtl/szt_if.sv @@
// Channel interfaces for the request and the response of the zone tracker.
interface szt_req_if import szt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [2:0]                   req_type;
   logic [15:0]                  zone_tag;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   logic [RAD_W-1:0]             radius_in;
   logic                         enable_in;
   logic [2:0]                   preset_in;
   logic [7:0]                   wet_in;
   logic [15:0]                  decay_in;
   logic [15:0]                  predelay_in;
   modport source (output valid, req_type, zone_tag, pos_x, pos_y, pos_z, radius_in,
                   enable_in, preset_in, wet_in, decay_in, predelay_in, input ready);
   modport sink (input valid, req_type, zone_tag, pos_x, pos_y, pos_z, radius_in,
                 enable_in, preset_in, wet_in, decay_in, predelay_in, output ready);
endinterface

interface szt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [15:0] event_tag;
   logic        found;
   logic [2:0]  preset_out;
   logic [7:0]  wet_out;
   logic [15:0] decay_out;
   logic [15:0] predelay_out;
   logic        inside_now;
   logic [2:0]  effective_preset;
   logic        last_of_run;
   modport source (output valid, result_kind, event_tag, found, preset_out, wet_out,
                   decay_out, predelay_out, inside_now, effective_preset, last_of_run,
                   input ready);
   modport sink (input valid, result_kind, event_tag, found, preset_out, wet_out,
                 decay_out, predelay_out, inside_now, effective_preset, last_of_run,
                 output ready);
endinterface

@@ rtl/szt_zone_mem.sv @@
// Zone table memory with one write port and one registered read port.
module szt_zone_mem import szt_pkg::*; (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  zone_row_type       wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   output zone_row_type       rd_data
);

   zone_row_type mem [MAX_ZONES];
   zone_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sphere_zone_tracker_unit.sv @@
// Top level of the sphere zone tracker: sequencer, shared squaring unit and result register.
//
//   channel  | direction | transfer
//   req      | in        | valid && ready, one request
//   rsp      | out       | valid && ready, one result (one or two per request)
//   csr      | in        | csr_we high, global preset written
//
// A request is taken only when the sequencer is idle; req.ready is low meanwhile.
// Add runs ST_ADD then ST_RESP and clear runs ST_RESP alone, until ready again with rsp free.
// Update and look up scan each zone: SC_RD, SC_X if disabled; SC_RD to SC_CMP if enabled.
// Remove visits RM_RD and RM_CHK per entry searched and SH_RD and SH_WR per entry moved down.
// A stalled rsp holds the sequencer; reset is synchronous and empties the table.
module sphere_zone_tracker_unit import szt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   szt_req_if.sink    req,
   szt_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_ADD    = 13'b0000000000010,
      ST_SC_RD  = 13'b0000000000100,
      ST_SC_X   = 13'b0000000001000,
      ST_SC_Y   = 13'b0000000010000,
      ST_SC_Z   = 13'b0000000100000,
      ST_SC_R   = 13'b0000001000000,
      ST_SC_CMP = 13'b0000010000000,
      ST_RM_RD  = 13'b0000100000000,
      ST_RM_CHK = 13'b0001000000000,
      ST_SH_RD  = 13'b0010000000000,
      ST_SH_WR  = 13'b0100000000000,
      ST_RESP   = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;
   req_item_type     req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             inside_ff, inside_in;
   logic [15:0]      cur_tag_ff, cur_tag_in;
   logic [SND_W-1:0] cur_snd_ff, cur_snd_in;
   logic [2:0]       gp_ff;
   logic [2:0]       res_kind_ff, res_kind_in;
   logic [15:0]      res_tag_ff, res_tag_in;
   logic             res_found_ff, res_found_in;
   logic [SND_W-1:0] res_snd_ff, res_snd_in;
   logic             two_ff, two_in;
   logic [SQ_W-1:0]  prod_ff;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_pay_ff, rsp_pay_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   zone_row_type     mem_wdata, row;
   logic [MAG_W-1:0] mul_a;
   logic signed [MAG_W-1:0] diff;
   logic             dec_go, dec_hit;
   logic             rsp_free;
   logic [CNT_W-1:0] idx_next;

   szt_zone_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (row)
   );

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign idx_next = idx_ff + 1'b1;

   // Shared squaring unit: one coordinate difference or the radius per cycle.
   always_comb begin
      diff  = '0;
      mul_a = '0;
      case (state_ff)
         ST_SC_X: diff = {req_ff.pos_x[COORD_BITS-1], req_ff.pos_x}
                         - {row.cx[COORD_BITS-1], row.cx};
         ST_SC_Y: diff = {req_ff.pos_y[COORD_BITS-1], req_ff.pos_y}
                         - {row.cy[COORD_BITS-1], row.cy};
         ST_SC_Z: diff = {req_ff.pos_z[COORD_BITS-1], req_ff.pos_z}
                         - {row.cz[COORD_BITS-1], row.cz};
         default: diff = '0;
      endcase
      if (state_ff == ST_SC_R) begin
         mul_a = {2'b00, row.radius};
      end else begin
         mul_a = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      inside_in    = inside_ff;
      cur_tag_in   = cur_tag_ff;
      cur_snd_in   = cur_snd_ff;
      res_kind_in  = res_kind_ff;
      res_tag_in   = res_tag_ff;
      res_found_in = res_found_ff;
      res_snd_in   = res_snd_ff;
      two_in       = two_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pay_in   = rsp_pay_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[IDX_W-1:0];
      mem_wdata    = row;
      mem_raddr    = idx_ff[IDX_W-1:0];
      dec_go       = 1'b0;
      dec_hit      = 1'b0;
      req.ready    = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               req_in.req_type = req.req_type;
               req_in.zone_tag = req.zone_tag;
               req_in.pos_x    = req.pos_x;
               req_in.pos_y    = req.pos_y;
               req_in.pos_z    = req.pos_z;
               req_in.radius   = req.radius_in;
               req_in.enable   = req.enable_in;
               req_in.snd      = {req.preset_in, req.wet_in, req.decay_in, req.predelay_in};
               idx_in          = '0;
               res_kind_in     = KIND_DONE;
               res_tag_in      = '0;
               res_found_in    = 1'b0;
               res_snd_in      = '0;
               two_in          = 1'b0;
               case (req.req_type)
                  REQ_ADD:    state_in = ST_ADD;
                  REQ_REMOVE: state_in = ST_RM_RD;
                  REQ_CLEAR: begin
                     count_in   = '0;
                     inside_in  = 1'b0;
                     cur_tag_in = '0;
                     cur_snd_in = '0;
                     state_in   = ST_RESP;
                  end
                  REQ_UPDATE: state_in = ST_SC_RD;
                  REQ_LOOKUP: state_in = ST_SC_RD;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_ADD: begin
            if (count_ff >= CNT_W'(MAX_ZONES)) begin
               res_kind_in = KIND_FULL;
            end else begin
               mem_we           = 1'b1;
               mem_waddr        = count_ff[IDX_W-1:0];
               mem_wdata.cx     = req_ff.pos_x;
               mem_wdata.cy     = req_ff.pos_y;
               mem_wdata.cz     = req_ff.pos_z;
               mem_wdata.radius = req_ff.radius;
               mem_wdata.enable = req_ff.enable;
               mem_wdata.snd    = req_ff.snd;
               mem_wdata.tag    = req_ff.zone_tag;
               count_in         = count_ff + 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_SC_RD: begin
            if (idx_ff >= count_ff) begin
               dec_go = 1'b1;
            end else begin
               state_in = ST_SC_X;
            end
         end
         ST_SC_X: begin
            if (!row.enable) begin
               idx_in   = idx_next;
               state_in = ST_SC_RD;
            end else begin
               state_in = ST_SC_Y;
            end
         end
         ST_SC_Y: begin
            acc_in   = ACC_W'(prod_ff);
            state_in = ST_SC_Z;
         end
         ST_SC_Z: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = ST_SC_R;
         end
         ST_SC_R: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            if (acc_ff <= ACC_W'(prod_ff)) begin
               dec_go  = 1'b1;
               dec_hit = 1'b1;
            end else begin
               idx_in   = idx_next;
               state_in = ST_SC_RD;
            end
         end
         ST_RM_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_RM_CHK;
            end
         end
         ST_RM_CHK: begin
            if (row.tag == req_ff.zone_tag) begin
               state_in = ST_SH_RD;
            end else begin
               idx_in   = idx_next;
               state_in = ST_RM_RD;
            end
         end
         ST_SH_RD: begin
            mem_raddr = idx_next[IDX_W-1:0];
            if (idx_next < count_ff) begin
               state_in = ST_SH_WR;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_SH_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_next;
            state_in = ST_SH_RD;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_pay_in.result_kind      = res_kind_ff;
               rsp_pay_in.event_tag        = res_tag_ff;
               rsp_pay_in.found            = res_found_ff;
               rsp_pay_in.snd              = (res_kind_ff == KIND_LOOKUP) ? res_snd_ff
                                                                          : cur_snd_ff;
               rsp_pay_in.inside_now       = inside_ff;
               rsp_pay_in.effective_preset = inside_ff ? cur_snd_ff[SND_W-1:SND_W-3] : gp_ff;
               rsp_pay_in.last_of_run      = !two_ff;
               if (two_ff) begin
                  two_in      = 1'b0;
                  res_kind_in = KIND_ENTER;
                  res_tag_in  = cur_tag_ff;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (dec_go) begin
         state_in = ST_RESP;
         if (req_ff.req_type == REQ_LOOKUP) begin
            res_kind_in  = KIND_LOOKUP;
            res_found_in = dec_hit;
            res_tag_in   = dec_hit ? row.tag : 16'd0;
            res_snd_in   = dec_hit ? row.snd : '0;
         end else if (dec_hit) begin
            if (cur_tag_ff != row.tag) begin
               cur_tag_in = row.tag;
               cur_snd_in = row.snd;
               inside_in  = 1'b1;
               if (inside_ff) begin
                  res_kind_in = KIND_EXIT;
                  res_tag_in  = cur_tag_ff;
                  two_in      = 1'b1;
               end else begin
                  res_kind_in = KIND_ENTER;
                  res_tag_in  = row.tag;
               end
            end
         end else if (inside_ff) begin
            res_kind_in = KIND_EXIT;
            res_tag_in  = cur_tag_ff;
            cur_tag_in  = '0;
            inside_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         inside_ff    <= 1'b0;
         cur_tag_ff   <= '0;
         cur_snd_ff   <= '0;
         gp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         two_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         inside_ff    <= inside_in;
         cur_tag_ff   <= cur_tag_in;
         cur_snd_ff   <= cur_snd_in;
         rsp_valid_ff <= rsp_valid_in;
         two_ff       <= two_in;
         if (csr_we) begin
            gp_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      res_kind_ff  <= res_kind_in;
      res_tag_ff   <= res_tag_in;
      res_found_ff <= res_found_in;
      res_snd_ff   <= res_snd_in;
      acc_ff       <= acc_in;
      prod_ff      <= mul_a * mul_a;
      rsp_pay_ff   <= rsp_pay_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.result_kind      = rsp_pay_ff.result_kind;
   assign rsp.event_tag        = rsp_pay_ff.event_tag;
   assign rsp.found            = rsp_pay_ff.found;
   assign rsp.preset_out       = rsp_pay_ff.snd[42:40];
   assign rsp.wet_out          = rsp_pay_ff.snd[39:32];
   assign rsp.decay_out        = rsp_pay_ff.snd[31:16];
   assign rsp.predelay_out     = rsp_pay_ff.snd[15:0];
   assign rsp.inside_now       = rsp_pay_ff.inside_now;
   assign rsp.effective_preset = rsp_pay_ff.effective_preset;
   assign rsp.last_of_run      = rsp_pay_ff.last_of_run;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ZONES))
      else $error("Zone count exceeds the table depth.");

   a_enter_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pay_ff.result_kind == KIND_ENTER) |-> rsp_pay_ff.inside_now)
      else $error("Entry result while not inside a zone.");

   a_exit_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pay_ff.result_kind == KIND_EXIT && rsp_pay_ff.last_of_run)
      |-> !rsp_pay_ff.inside_now)
      else $error("Final exit result while still inside a zone.");

   a_found_lookup: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pay_ff.found) |-> (rsp_pay_ff.result_kind == KIND_LOOKUP))
      else $error("Found flag set outside a lookup answer.");

endmodule
